// ----- rtl/glpm_pkg.sv -----
// ----------------------------------------------------------------------------
// glpm_pkg: shared types and constants of the glob pattern-list matcher
// Pattern capacity, operation codes, character codes and the control and
// status bundles passed between the top level and the position cells.
// ----------------------------------------------------------------------------
package glpm_pkg;

  localparam int PAT_CHARS  = 32;
  localparam int POS_W      = PAT_CHARS + 1;
  localparam int LEN_W      = $clog2(PAT_CHARS + 1);
  localparam int CLOSE_LVLS = $clog2(POS_W);

  localparam int CNT_W      = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd4;

  localparam int OP_W       = 2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_NAME   = 2'd2;
  localparam logic [OP_W-1:0] OP_END    = 2'd3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Broadcast from the control section to every position cell.
  typedef struct packed {
    logic       clr;       // pattern cleared
    logic       wr_sep;    // separator appended
    logic       wr_nb;     // non-blank pattern byte appended
    logic       pend_en;   // blank appended inside an alternative
    logic       first_nb;  // no non-blank byte yet in the open alternative
    logic       u_ok;      // open alternative counts (non-empty, not trivial)
    logic       fresh;     // active set equals the start closure
    logic       step;      // name byte advances the automaton
    logic [7:0] wr_byte;   // pattern byte being appended
    logic [7:0] name_fold; // lower-cased name byte
  } cell_ctl_t;

  // Per-position status back to the control section and the neighbor.
  typedef struct packed {
    logic act_e;  // position currently active
    logic acc_e;  // position ends an alternative
    logic tbit;   // position is a star inside an alternative
    logic keep;   // star position stays active
    logic adv;    // match moves on to the next position
    logic carry;  // leading star run reaches the next position
  } cell_stat_t;

  function automatic logic [7:0] fold_ch(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

// ----- rtl/glpm_cell.sv -----
// ----------------------------------------------------------------------------
// glpm_cell: one pattern position
// Holds the pattern byte at its position, the alternative masks for that
// position and its active bit, and hands match and setup signals to the
// next cell.
// ----------------------------------------------------------------------------
module glpm_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glpm_pkg::cell_ctl_t   ctl,
  input  logic                  sel,         // this position takes the appended byte
  input  logic                  sel_prev,    // previous position takes the appended byte
  input  logic                  carry_prev,  // previous position passes a start star
  input  logic                  nxt_act,     // closed next-state bit for this position
  output glpm_pkg::cell_stat_t  stat
);
  import glpm_pkg::*;

  logic [7:0] ch_r;
  logic       c_body_r, c_init_r, c_acc_r;
  logic       u_body_r, u_init_r, u_acc_r, pend_r;
  logic       act_r;

  logic       is_star, is_qm;
  logic       body_e, init_e;

  assign is_star = (ch_r == CH_STAR);
  assign is_qm   = (ch_r == CH_QMARK);

  assign body_e     = c_body_r | (ctl.u_ok & u_body_r);
  assign init_e     = c_init_r | (ctl.u_ok & u_init_r);
  assign stat.acc_e = c_acc_r  | (ctl.u_ok & u_acc_r);
  assign stat.act_e = ctl.fresh ? init_e : act_r;
  assign stat.tbit  = body_e & is_star;
  assign stat.keep  = stat.act_e & stat.tbit;
  assign stat.adv   = stat.act_e & body_e & ~is_star &
                      (is_qm | (fold_ch(ch_r) == ctl.name_fold));
  // A star written at a start position, or after a run of leading stars,
  // makes the following position a start position as well.
  assign stat.carry = sel & ctl.wr_nb & (ctl.wr_byte == CH_STAR) &
                      (u_init_r | ctl.first_nb);

  always_ff @(posedge clk) begin
    if (sel) begin
      ch_r <= ctl.wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_body_r <= 1'b0;
      c_init_r <= 1'b0;
      c_acc_r  <= 1'b0;
      u_body_r <= 1'b0;
      u_init_r <= 1'b0;
      u_acc_r  <= 1'b0;
      pend_r   <= 1'b0;
      act_r    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        c_body_r <= 1'b0;
        c_init_r <= 1'b0;
        c_acc_r  <= 1'b0;
        u_body_r <= 1'b0;
        u_init_r <= 1'b0;
        u_acc_r  <= 1'b0;
        pend_r   <= 1'b0;
      end else if (ctl.wr_sep) begin
        if (ctl.u_ok) begin
          c_body_r <= c_body_r | u_body_r;
          c_init_r <= c_init_r | u_init_r;
          c_acc_r  <= c_acc_r  | u_acc_r;
        end
        u_body_r <= 1'b0;
        u_init_r <= 1'b0;
        u_acc_r  <= 1'b0;
        pend_r   <= 1'b0;
      end else if (ctl.wr_nb) begin
        // Blanks between two non-blank bytes become part of the alternative.
        u_body_r <= u_body_r | pend_r | sel;
        pend_r   <= 1'b0;
        u_acc_r  <= sel_prev;
        u_init_r <= u_init_r | (ctl.first_nb & sel) | carry_prev;
      end else if (ctl.pend_en) begin
        pend_r <= pend_r | sel;
      end
      if (ctl.step) begin
        act_r <= nxt_act;
      end
    end
  end

endmodule

// ----- rtl/glpm_close.sv -----
// ----------------------------------------------------------------------------
// glpm_close: star closure network
// Lets every active star also stand for an empty run, so activity ripples
// forward through runs of stars; built as a log-depth prefix network.
// ----------------------------------------------------------------------------
module glpm_close (
  input  logic [glpm_pkg::POS_W-1:0] seed,
  input  logic [glpm_pkg::POS_W-1:0] tx,
  output logic [glpm_pkg::POS_W-1:0] closed
);
  import glpm_pkg::*;

  logic [POS_W-1:0] act_l [CLOSE_LVLS+1];
  logic [POS_W-1:0] pas_l [CLOSE_LVLS];

  assign act_l[0] = seed;
  assign pas_l[0] = tx;

  // After level k a bit reaches up to 2**(k+1)-1 positions forward;
  // pas_l[k] marks runs of 2**k passing positions.
  for (genvar k = 0; k < CLOSE_LVLS; k++) begin : g_lvl
    assign act_l[k+1] = act_l[k] | ((act_l[k] & pas_l[k]) << (1 << k));
    if (k + 1 < CLOSE_LVLS) begin : g_pas
      assign pas_l[k+1] = pas_l[k] & (pas_l[k] >> (1 << k));
    end
  end

  assign closed = act_l[CLOSE_LVLS];

endmodule

// ----- rtl/glob_pattern_list_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_pattern_list_matcher: case-insensitive wildcard matcher, pattern list
// Pattern bytes build a list of ';'-separated alternatives in a row of
// position cells; name bytes then step a bit-parallel automaton over them.
//
//   channel  dir  tdata                       tuser
//   in_      in   [7:0] data_byte             [1:0] opcode
//   out_     out  [0] matched, [1] overflow   -
//
// A new item can be taken each cycle while the input is not stalled.
// The critical path is the cell compare followed by the star closure network.
// An end-of-name result sits in an output register; input is stalled only
// while that register is full and out_tready is low.
// Synchronous active-low reset leaves an empty pattern; no clearing pass.
// ----------------------------------------------------------------------------
module glob_pattern_list_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [glpm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic [glpm_pkg::OP_W-1:0]           in_tuser,   // [1:0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [glpm_pkg::OUT_TDATA_W-1:0]    out_tdata   // [0] matched, [1] pattern_overflow
);
  import glpm_pkg::*;

  logic             in_acc;
  logic             op_clr, op_app, op_name, op_end;
  logic             do_app, is_sep, is_blank, is_nb;
  logic             trivial;
  logic             hit;

  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic             fresh_r;
  logic             always_r;
  logic             seg_has_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, seg_len_r;
  logic [7:0]       ch0_r, ch1_r, ch2_r;
  logic             out_valid_r, matched_r, ovf_out_r;

  cell_ctl_t        ctl;
  cell_stat_t       stat [POS_W];
  logic [POS_W-1:0] sel, sel_prev, carry_prev;
  logic [POS_W-1:0] keep_v, adv_v, tx_v, next_v, closed_v, hit_v;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign op_clr    = in_acc & (in_tuser == OP_CLEAR);
  assign op_app    = in_acc & (in_tuser == OP_APPEND);
  assign op_name   = in_acc & (in_tuser == OP_NAME);
  assign op_end    = in_acc & (in_tuser == OP_END);

  assign do_app   = op_app & (len_r != LEN_W'(PAT_CHARS));
  assign is_sep   = (in_tdata == CH_SEMI);
  assign is_blank = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB);
  assign is_nb    = ~is_sep & ~is_blank;

  assign trivial = (seg_len_r == CNT_W'(1) && ch0_r == CH_STAR) ||
                   (seg_len_r == CNT_W'(3) && ch0_r == CH_STAR &&
                    ch1_r == CH_DOT && ch2_r == CH_STAR);

  assign cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    ctl.clr       = op_clr;
    ctl.wr_sep    = do_app & is_sep;
    ctl.wr_nb     = do_app & is_nb;
    ctl.pend_en   = do_app & is_blank & seg_has_r;
    ctl.first_nb  = ~seg_has_r;
    ctl.u_ok      = seg_has_r & ~trivial;
    ctl.fresh     = fresh_r;
    ctl.step      = op_name;
    ctl.wr_byte   = in_tdata;
    ctl.name_fold = fold_ch(in_tdata);
  end

  for (genvar i = 0; i < POS_W; i++) begin : g_sel
    assign sel[i] = do_app & (len_r == LEN_W'(i));
  end

  assign sel_prev      = {sel[POS_W-2:0], 1'b0};
  assign carry_prev[0] = 1'b0;

  for (genvar i = 1; i < POS_W; i++) begin : g_carry
    assign carry_prev[i] = stat[i-1].carry;
  end

  for (genvar i = 0; i < POS_W; i++) begin : g_cell
    glpm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sel        (sel[i]),
      .sel_prev   (sel_prev[i]),
      .carry_prev (carry_prev[i]),
      .nxt_act    (closed_v[i]),
      .stat       (stat[i])
    );
    assign keep_v[i] = stat[i].keep;
    assign adv_v[i]  = stat[i].adv;
    assign tx_v[i]   = stat[i].tbit;
    assign hit_v[i]  = stat[i].act_e & stat[i].acc_e;
  end

  // Stars hold their own position; other matches move one position on.
  assign next_v = keep_v | {adv_v[POS_W-2:0], 1'b0};

  glpm_close u_close (
    .seed   (next_v),
    .tx     (tx_v),
    .closed (closed_v)
  );

  // The open alternative, when it is a lone star or star-dot-star, matches
  // any name just like a closed one.
  assign hit = always_r | (seg_has_r & trivial) | (|hit_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      fresh_r   <= 1'b1;
      always_r  <= 1'b0;
      seg_has_r <= 1'b0;
      cnt_r     <= '0;
      seg_len_r <= '0;
    end else begin
      if (op_clr || op_app || op_end) begin
        fresh_r <= 1'b1;
      end else if (op_name) begin
        fresh_r <= 1'b0;
      end

      if (op_clr) begin
        len_r     <= '0;
        ovf_r     <= 1'b0;
        always_r  <= 1'b0;
        seg_has_r <= 1'b0;
        cnt_r     <= '0;
        seg_len_r <= '0;
      end else if (op_app && !do_app) begin
        ovf_r <= 1'b1;
      end else if (do_app) begin
        len_r <= len_r + LEN_W'(1);
        if (is_sep) begin
          if (seg_has_r && trivial) begin
            always_r <= 1'b1;
          end
          seg_has_r <= 1'b0;
          cnt_r     <= '0;
          seg_len_r <= '0;
        end else if (!seg_has_r) begin
          if (is_nb) begin
            seg_has_r <= 1'b1;
            cnt_r     <= CNT_W'(1);
            seg_len_r <= CNT_W'(1);
          end
        end else begin
          cnt_r <= cnt_nxt;
          if (is_nb) begin
            seg_len_r <= cnt_nxt;
          end
        end
      end
    end
  end

  // The first three bytes of the open alternative, for the match-all test.
  always_ff @(posedge clk) begin
    if (do_app && !is_sep) begin
      if (!seg_has_r && is_nb) begin
        ch0_r <= in_tdata;
      end
      if (seg_has_r && cnt_r == CNT_W'(1)) begin
        ch1_r <= in_tdata;
      end
      if (seg_has_r && cnt_r == CNT_W'(2)) begin
        ch2_r <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_end) begin
      matched_r <= hit;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, ovf_out_r, matched_r};

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PAT_CHARS))
    else $error("pattern length beyond capacity");

  a_sel_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel))
    else $error("more than one cell selected for a pattern write");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    op_end |=> (out_valid_r && fresh_r))
    else $error("end of name did not produce a result and restart");

  a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ovf_r) |-> $past(op_clr))
    else $error("overflow flag dropped without a clear");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while a result is stalled");
`endif

endmodule
